FILE: hw/rtl/lower_triangular_matvec_accumulate_macros.svh
// Assertion macros for the lower-triangular matrix-vector block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LOWER_TRIANGULAR_MATVEC_ACCUMULATE_MACROS_SVH
`define LOWER_TRIANGULAR_MATVEC_ACCUMULATE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds on every clock edge outside reset.
`define LTMV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define LTMV_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`else

`define LTMV_ASSERT(lbl, clk, rstn, prop, msg)
`define LTMV_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg)

`endif

`endif

FILE: hw/rtl/ltmv_pkg.sv
// Shared types and constants for the lower-triangular matrix-vector block.
// No dependencies; compiled first.
package ltmv_pkg;

    localparam int MAX_DIM_DEF = 64;

    localparam int DIM_W    = 7;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam int ACT_W    = 2;
    localparam int ROW_W    = 6;
    localparam int INDEX_W  = 6;
    localparam int COEF_W   = 24;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int FRAC_W   = 12;
    localparam int Z_W      = 32;
    localparam int SUM_W    = 48;
    localparam int VEC_W    = SUM_W + SAMPLE_W;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_SEL_W = PADDR_W - 2;
    localparam logic [REG_SEL_W-1:0] REG_DIM = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH1,
        ST_FLUSH2,
        ST_ZSAT,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic clr;
        logic mul_v;
    } mac_ctrl_t;

endpackage

FILE: hw/rtl/ltmv_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on ltmv_pkg for field widths.
interface ltmv_in_if;
    import ltmv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACT_W-1:0]          action;
    logic [ROW_W-1:0]          row;
    logic [ROW_W-1:0]          col;
    logic signed [COEF_W-1:0]  coef;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output action, output row, output col,
                    output coef, output sample, input ready);
    modport sink   (input valid, input action, input row, input col,
                    input coef, input sample, output ready);
endinterface

interface ltmv_out_if;
    import ltmv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [INDEX_W-1:0]       index;
    logic signed [Z_W-1:0]    z_value;
    logic signed [SUM_W-1:0]  sum_value;
    logic                     last;

    modport source (output valid, output index, output z_value, output sum_value,
                    output last, input ready);
    modport sink   (input valid, input index, input z_value, input sum_value,
                    input last, output ready);
endinterface

FILE: hw/rtl/ltmv_cfg.sv
// APB-style register port holding the vector length, and its clamped form.
// Depends on ltmv_pkg.
module ltmv_cfg #(
    parameter int MAX_DIM = ltmv_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ltmv_pkg::PADDR_W-1:0]      paddr,
    input  logic [ltmv_pkg::PDATA_W-1:0]      pwdata,
    output logic [ltmv_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output logic [$clog2(MAX_DIM+1)-1:0]      dim_eff
);
    import ltmv_pkg::*;

    localparam int N_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0] dim_reg;
    logic             dim_sel;
    logic             dim_we;

    assign pready  = 1'b1;
    assign dim_sel = (paddr[PADDR_W-1:2] == REG_DIM);
    assign dim_we  = psel && penable && pwrite && pready && dim_sel;
    assign prdata  = dim_sel ? PDATA_W'(dim_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (dim_we)
        begin
            dim_reg <= pwdata[DIM_W-1:0];
        end
    end

    // zero acts as one, anything past the array size as the array size
    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_eff = N_W'(1);
        end
        else if (32'(dim_reg) > MAX_DIM)
        begin
            dim_eff = N_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = N_W'(dim_reg);
        end
    end

endmodule

FILE: hw/rtl/ltmv_mac.sv
// Multiply-accumulate unit: one registered product and one accumulator.
// Depends on ltmv_pkg.
module ltmv_mac #(
    parameter int MAX_DIM = ltmv_pkg::MAX_DIM_DEF
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  ltmv_pkg::mac_ctrl_t                                       ctrl,
    input  logic signed [ltmv_pkg::COEF_W-1:0]                        coef,
    input  logic signed [ltmv_pkg::SAMPLE_W-1:0]                      sample,
    output logic signed [ltmv_pkg::PROD_W+$clog2(MAX_DIM)-1:0]        acc
);
    import ltmv_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(MAX_DIM);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.mul_v;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sample;
        if (ctrl.clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hw/rtl/ltmv_engine.sv
// Sequencer with the factor memory, the sample/sum memory and the result register.
// Depends on ltmv_pkg, ltmv_if, ltmv_mac and the assertion macro header.
`include "lower_triangular_matvec_accumulate_macros.svh"

module ltmv_engine #(
    parameter int MAX_DIM = ltmv_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ltmv_in_if.sink                      item,
    ltmv_out_if.source                   result,
    input  logic [$clog2(MAX_DIM+1)-1:0] dim_eff
);
    import ltmv_pkg::*;

    localparam int N_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CA_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
    localparam int SH_W  = ACC_W - FRAC_W;
    localparam int EXT_W = (SH_W > Z_W) ? SH_W : Z_W + 1;

    localparam logic signed [EXT_W-1:0] ZHI_EXT = {{(EXT_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] ZLO_EXT = {{(EXT_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};
    localparam logic signed [Z_W-1:0]   Z_MAX   = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0]   Z_MIN   = {1'b1, {(Z_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] S_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    // memories
    logic [COEF_W-1:0] coef_mem [MAX_DIM*MAX_DIM];
    logic [VEC_W-1:0]  vec_mem  [MAX_DIM];
    logic [COEF_W-1:0] coef_rd_reg;
    logic [VEC_W-1:0]  vec_rd_reg;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   position_reg, position_next;
    logic [MAX_DIM-1:0] sum_valid_reg, sum_valid_next;
    logic               rd_v_reg;
    logic signed [Z_W-1:0] z_reg;

    logic                    out_valid_reg;
    logic [INDEX_W-1:0]      out_index_reg;
    logic signed [Z_W-1:0]   out_z_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                    out_last_reg;

    // FSM outputs
    logic item_rdy;
    logic mac_issue;
    logic sum_rd;
    logic z_load;
    logic done;

    logic accept;
    logic acc_write;
    logic acc_sample;
    logic acc_clear;
    logic coef_we;
    logic samp_we;
    logic [IDX_W-1:0] i_new;
    logic [CA_W-1:0]  coef_waddr;
    logic [CA_W-1:0]  coef_raddr;
    logic [IDX_W-1:0] vec_waddr;
    logic [IDX_W-1:0] vec_raddr;
    logic             vec_re;
    logic             is_last;

    logic signed [ACC_W-1:0]   acc;
    logic signed [SH_W-1:0]    sh;
    logic signed [EXT_W-1:0]   sh_ext;
    logic signed [Z_W-1:0]     z_sat;
    logic signed [SUM_W-1:0]   sum_old;
    logic signed [SUM_W:0]     sum_w;
    logic signed [SUM_W-1:0]   sum_sat;
    mac_ctrl_t                 mac_ctrl;

    assign accept     = item.valid && item.ready;
    assign acc_write  = accept && (item.action == ACT_WRITE);
    assign acc_sample = accept && (item.action == ACT_SAMPLE);
    assign acc_clear  = accept && (item.action == ACT_CLEAR);

    // ignore writes outside the array or above the diagonal
    assign coef_we = acc_write && (32'(item.row) < MAX_DIM) && (32'(item.col) < MAX_DIM)
                     && (item.col <= item.row);
    assign coef_waddr = CA_W'(CA_W'(item.row) * CA_W'(MAX_DIM) + CA_W'(item.col));
    assign coef_raddr = CA_W'(CA_W'(i_reg) * CA_W'(MAX_DIM) + CA_W'(j_reg));

    // restart at zero when the length was lowered to or below the position
    assign i_new   = (N_W'(position_reg) >= dim_eff) ? '0 : position_reg;
    assign samp_we = acc_sample;
    assign vec_waddr = done ? i_reg : i_new;
    assign vec_raddr = sum_rd ? i_reg : j_reg;
    assign vec_re    = mac_issue || sum_rd;
    assign is_last   = ((N_W'(i_reg) + N_W'(1)) == dim_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_sample)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (j_reg == i_reg)
                begin
                    state_next = ST_FLUSH1;
                end
            end
            ST_FLUSH1: state_next = ST_FLUSH2;
            ST_FLUSH2: state_next = ST_ZSAT;
            ST_ZSAT:   state_next = ST_SUM;
            ST_SUM:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        item_rdy  = 1'b0;
        mac_issue = 1'b0;
        sum_rd    = 1'b0;
        z_load    = 1'b0;
        done      = 1'b0;
        case (state_reg)
            ST_IDLE:   item_rdy  = 1'b1;
            ST_MAC:    mac_issue = 1'b1;
            ST_FLUSH1: sum_rd    = 1'b1;
            ST_FLUSH2: ;
            ST_ZSAT:   z_load    = 1'b1;
            ST_SUM:    done      = !out_valid_reg || result.ready;
            default:   ;
        endcase
    end

    assign item.ready = item_rdy;

    // index registers, position and sum valid bits
    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        position_next  = position_reg;
        sum_valid_next = sum_valid_reg;
        if (acc_sample)
        begin
            i_next = i_new;
            j_next = '0;
        end
        if (mac_issue && (j_reg != i_reg))
        begin
            j_next = j_reg + IDX_W'(1);
        end
        if (acc_clear)
        begin
            sum_valid_next = '0;
        end
        if (done)
        begin
            sum_valid_next[i_reg] = 1'b1;
            position_next = is_last ? '0 : i_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            position_reg  <= '0;
            sum_valid_reg <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            position_reg  <= position_next;
            sum_valid_reg <= sum_valid_next;
            rd_v_reg      <= mac_issue;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // factor memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= item.coef;
        end
        if (mac_issue)
        begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    // sample/sum memory: sample in the low field, running sum above it
    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            vec_mem[vec_waddr][SAMPLE_W-1:0] <= item.sample;
        end
        if (done)
        begin
            vec_mem[vec_waddr][VEC_W-1:SAMPLE_W] <= sum_sat;
        end
        if (vec_re)
        begin
            vec_rd_reg <= vec_mem[vec_raddr];
        end
    end

    assign mac_ctrl.clr   = acc_sample;
    assign mac_ctrl.mul_v = rd_v_reg;

    ltmv_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (signed'(coef_rd_reg)),
        .sample (signed'(vec_rd_reg[SAMPLE_W-1:0])),
        .acc    (acc)
    );

    // drop fraction bits (floor), then saturate to the result width
    assign sh     = SH_W'(acc >>> FRAC_W);
    assign sh_ext = EXT_W'(sh);

    always_comb
    begin
        if (sh_ext > ZHI_EXT)
        begin
            z_sat = Z_MAX;
        end
        else if (sh_ext < ZLO_EXT)
        begin
            z_sat = Z_MIN;
        end
        else
        begin
            z_sat = Z_W'(sh_ext);
        end
    end

    assign sum_old = sum_valid_reg[i_reg] ? signed'(vec_rd_reg[VEC_W-1:SAMPLE_W]) : '0;
    assign sum_w   = (SUM_W+1)'(sum_old) + (SUM_W+1)'(z_reg);

    always_comb
    begin
        if (sum_w[SUM_W] != sum_w[SUM_W-1])
        begin
            sum_sat = sum_w[SUM_W] ? S_MIN : S_MAX;
        end
        else
        begin
            sum_sat = SUM_W'(sum_w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (z_load)
        begin
            z_reg <= z_sat;
        end
        if (done)
        begin
            out_index_reg <= INDEX_W'(i_reg);
            out_z_reg     <= z_reg;
            out_sum_reg   <= sum_sat;
            out_last_reg  <= is_last;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.index     = out_index_reg;
    assign result.z_value   = out_z_reg;
    assign result.sum_value = out_sum_reg;
    assign result.last      = out_last_reg;

    `LTMV_ASSERT(a_ready_idle, clk, rst_n, (state_reg != ST_IDLE) |-> !item.ready, "item taken while busy")
    `LTMV_ASSERT(a_col_bound, clk, rst_n, (state_reg == ST_MAC) |-> (j_reg <= i_reg), "column past diagonal")
    `LTMV_ASSERT(a_pipe_empty, clk, rst_n, (state_reg == ST_ZSAT) |-> !rd_v_reg, "MAC pipe not drained")
    `LTMV_ASSERT(a_load_src, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_SUM), "result loaded outside sum step")
    `LTMV_ASSERT_NEXT(a_mac_start, clk, rst_n, acc_sample, (state_reg == ST_MAC) && (j_reg == '0), "sample did not start at column zero")

endmodule

FILE: hw/rtl/lower_triangular_matvec_accumulate.sv
// Factor write and clear items are taken in the idle state and leave it idle. A sample item
// at index i holds the block while it steps through columns 0 to i and the flush, saturate
// and sum states; the single multiply-accumulate is fed by one factor memory read a cycle.
// A waiting result does not hold back writes or clears; a sample stalls only at its end.
// Reset is asynchronous: the length returns to 64, the running sums read as zero at once
// through per-index valid bits, and factor and sample memories stay undefined until written.
module lower_triangular_matvec_accumulate #(
    parameter int MAX_DIM = ltmv_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ltmv_pkg::PADDR_W-1:0]  paddr,
    input  logic [ltmv_pkg::PDATA_W-1:0]  pwdata,
    output logic [ltmv_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    ltmv_in_if.sink                       item,
    ltmv_out_if.source                    result
);
    import ltmv_pkg::*;

    logic [$clog2(MAX_DIM+1)-1:0] dim_eff;

    ltmv_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim_eff (dim_eff)
    );

    ltmv_engine #(
        .MAX_DIM (MAX_DIM)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .dim_eff (dim_eff)
    );

endmodule
